[sv/tass_pkg.sv]
package tass_pkg;

   localparam int NUM_AXES_DEFAULT      = 3;
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int IO_AXES               = 3;
   localparam int FIELD_BITS            = 16;
   localparam int RESET_POSITION        = 1875;

   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_TICK = 1'b1
   } action_type;

   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      logic take;
      logic load;
   } step_ctrl_type;

endpackage

[sv/tass_if.sv]
interface tass_req_if;
   import tass_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   field_type  target_base;
   field_type  target_lower;
   field_type  target_upper;
   field_type  step_base;
   field_type  step_lower;
   field_type  step_upper;

   modport source (
      output valid, action, target_base, target_lower, target_upper,
             step_base, step_lower, step_upper,
      input  ready
   );
   modport sink (
      input  valid, action, target_base, target_lower, target_upper,
             step_base, step_lower, step_upper,
      output ready
   );
endinterface

interface tass_rsp_if;
   import tass_pkg::*;

   logic      valid;
   logic      ready;
   field_type pos_base;
   field_type pos_lower;
   field_type pos_upper;
   logic      done_base;
   logic      done_lower;
   logic      done_upper;
   logic      move_done;

   modport source (
      output valid, pos_base, pos_lower, pos_upper, done_base, done_lower,
             done_upper, move_done,
      input  ready
   );
   modport sink (
      input  valid, pos_base, pos_lower, pos_upper, done_base, done_lower,
             done_upper, move_done,
      output ready
   );
endinterface

[sv/tass_axis.sv]
module tass_axis #(
   parameter int POSITION_BITS = tass_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tass_pkg::step_ctrl_type  ctrl,
   input  logic [POSITION_BITS-1:0] load_target,
   input  logic [POSITION_BITS-1:0] load_step,
   output logic [POSITION_BITS-1:0] position,
   output logic                     done
);
   import tass_pkg::*;

   localparam logic [POSITION_BITS-1:0] RESET_POS = POSITION_BITS'(RESET_POSITION);

   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] target_ff, target_in;
   logic [POSITION_BITS-1:0] step_ff, step_in;
   logic                     done_ff, done_in;
   logic                     cur_done;
   logic [POSITION_BITS:0]   sum;
   logic [POSITION_BITS-1:0] gap;

   always_comb begin
      target_in   = ctrl.load ? load_target : target_ff;
      step_in     = ctrl.load ? load_step : step_ff;
      cur_done    = ctrl.load ? (load_step == '0) : done_ff;
      sum         = {1'b0, position_ff} + {1'b0, step_in};
      gap         = position_ff - target_in;
      position_in = position_ff;
      done_in     = cur_done;
      if (!cur_done) begin
         if (position_ff < target_in) begin
            if (sum > {1'b0, target_in}) begin
               position_in = target_in;
               done_in     = 1'b1;
            end else begin
               position_in = sum[POSITION_BITS-1:0];
            end
         end else if (position_ff > target_in) begin
            if (gap < step_in) begin
               position_in = target_in;
               done_in     = 1'b1;
            end else begin
               position_in = position_ff - step_in;
            end
         end else begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= RESET_POS;
         target_ff   <= RESET_POS;
         step_ff     <= '0;
         done_ff     <= 1'b1;
      end else if (ctrl.take) begin
         position_ff <= position_in;
         target_ff   <= target_in;
         step_ff     <= step_in;
         done_ff     <= done_in;
      end
   end

   assign position = position_ff;
   assign done     = done_ff;

endmodule

[sv/three_axis_servo_slew_stepper_core.sv]
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle; the axis state registers double as the
// result register, so a new item is taken when no result is pending or when it is taken.
// Reset: positions and targets 1875, steps zero, all axes done, no result
// pending.
module three_axis_servo_slew_stepper_core #(
   parameter int NUM_AXES      = tass_pkg::NUM_AXES_DEFAULT,
   parameter int POSITION_BITS = tass_pkg::POSITION_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   tass_req_if.sink   req_chan,
   tass_rsp_if.source rsp_chan
);
   import tass_pkg::*;

   localparam logic [POSITION_BITS-1:0] RESET_POS = POSITION_BITS'(RESET_POSITION);

   logic          rsp_valid_ff, rsp_valid_in;
   logic          take;
   step_ctrl_type ctrl;
   field_type     req_target [IO_AXES];
   field_type     req_step   [IO_AXES];
   field_type     out_pos    [IO_AXES];
   logic          out_done   [IO_AXES];
   logic [POSITION_BITS-1:0] axis_pos  [NUM_AXES];
   logic [NUM_AXES-1:0]      axis_done;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign ctrl.take      = take;
   assign ctrl.load      = (req_chan.action == ACTION_LOAD);

   assign req_target[0] = req_chan.target_base;
   assign req_target[1] = req_chan.target_lower;
   assign req_target[2] = req_chan.target_upper;
   assign req_step[0]   = req_chan.step_base;
   assign req_step[1]   = req_chan.step_lower;
   assign req_step[2]   = req_chan.step_upper;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic [POSITION_BITS-1:0] load_target;
      logic [POSITION_BITS-1:0] load_step;

      if (a < IO_AXES) begin : g_io
         assign load_target = POSITION_BITS'({{POSITION_BITS{1'b0}}, req_target[a]});
         assign load_step   = POSITION_BITS'({{POSITION_BITS{1'b0}}, req_step[a]});
      end else begin : g_spare
         // no input group: always loaded with zero step, so done at once
         assign load_target = RESET_POS;
         assign load_step   = '0;
      end

      tass_axis #(
         .POSITION_BITS(POSITION_BITS)
      ) u_axis (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load_target(load_target),
         .load_step  (load_step),
         .position   (axis_pos[a]),
         .done       (axis_done[a])
      );
   end

   for (genvar a = 0; a < IO_AXES; a++) begin : g_out
      if (a < NUM_AXES) begin : g_used
         assign out_pos[a]  = FIELD_BITS'({{FIELD_BITS{1'b0}}, axis_pos[a]});
         assign out_done[a] = axis_done[a];
      end else begin : g_unused
         assign out_pos[a]  = '0;
         assign out_done[a] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pos_base   = out_pos[0];
   assign rsp_chan.pos_lower  = out_pos[1];
   assign rsp_chan.pos_upper  = out_pos[2];
   assign rsp_chan.done_base  = out_done[0];
   assign rsp_chan.done_lower = out_done[1];
   assign rsp_chan.done_upper = out_done[2];
   assign rsp_chan.move_done  = &axis_done;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
   import tass_pkg::*;

   typedef struct packed {
      action_type action;
      field_type  target_base;
      field_type  target_lower;
      field_type  target_upper;
      field_type  step_base;
      field_type  step_lower;
      field_type  step_upper;
   } cmd_type;

   typedef struct packed {
      field_type pos_base;
      field_type pos_lower;
      field_type pos_upper;
      logic      done_base;
      logic      done_lower;
      logic      done_upper;
      logic      move_done;
   } pos_type;

   typedef struct packed {
      cmd_type cmd;
      logic    typed;
      pos_type want;
   } dir_row_type;

   localparam int DIRECTED_COUNT = 17;
   localparam int TOTAL_ITEMS    = 1950;
   localparam int CALM_FROM      = 1650;
   localparam int PAUSE_AT       = 900;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;
   localparam field_type HOME    = field_type'(RESET_POSITION);
   localparam field_type FMAX    = 16'hFFFF;

   // typed rows: state after reset, zero steps, snaps to the range limits
   localparam dir_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{'{ACTION_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        1'b1, '{HOME, HOME, HOME, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{ACTION_TICK, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX},
        1'b1, '{HOME, HOME, HOME, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{ACTION_LOAD, 16'd0, FMAX, 16'd1234, 16'd0, 16'd0, 16'd0},
        1'b1, '{HOME, HOME, HOME, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{ACTION_LOAD, FMAX, 16'd0, HOME, FMAX, FMAX, FMAX},
        1'b1, '{FMAX, 16'd0, HOME, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{ACTION_LOAD, 16'd0, FMAX, 16'd0, FMAX, FMAX, FMAX}, 1'b0, '0},
      '{'{ACTION_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
      '{'{ACTION_LOAD, 16'd100, 16'd200, 16'd300, 16'd30, 16'd1000, 16'd300},
        1'b0, '0},
      '{'{ACTION_TICK, 16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3},
        1'b0, '0},
      '{'{ACTION_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
      '{'{ACTION_LOAD, 16'd50, 16'd65000, 16'd0, 16'd7, FMAX, 16'd1}, 1'b0, '0},
      '{'{ACTION_TICK, FMAX, 16'd0, FMAX, 16'd0, FMAX, 16'd0}, 1'b0, '0},
      '{'{ACTION_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
      '{'{ACTION_LOAD, FMAX, FMAX, FMAX, 16'd1, 16'd1, 16'd1}, 1'b0, '0},
      '{'{ACTION_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
      '{'{ACTION_LOAD, 16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
      '{'{ACTION_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
      '{'{ACTION_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   tass_req_if req ();
   tass_rsp_if rsp ();

   three_axis_servo_slew_stepper_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   field_type slew_pos  [3];
   field_type slew_tgt  [3];
   field_type slew_step [3];
   logic      slew_done [3];

   pos_type pending_positions [$];

   logic    row_typed;
   pos_type row_want;
   logic    calm;
   int      stall_left = 0;
   int      errors;
   int      items_sent;
   int      loads_seen;
   int      ticks_seen;
   int      results_seen;
   int      snaps_seen;
   int      idle_cycles = 0;
   cmd_type mon_cmd;
   pos_type mon_got;
   pos_type mon_want;

   task automatic flag(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   task automatic next_positions(input cmd_type c, output pos_type r);
      field_type   tg [3];
      field_type   st [3];
      logic [16:0] sum;
      tg[0] = c.target_base;
      tg[1] = c.target_lower;
      tg[2] = c.target_upper;
      st[0] = c.step_base;
      st[1] = c.step_lower;
      st[2] = c.step_upper;
      if (c.action == ACTION_LOAD) begin
         for (int a = 0; a < 3; a++) begin
            slew_tgt[a]  = tg[a];
            slew_step[a] = st[a];
            slew_done[a] = (st[a] == '0);
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (!slew_done[a]) begin
            if (slew_pos[a] < slew_tgt[a]) begin
               sum = {1'b0, slew_pos[a]} + {1'b0, slew_step[a]};
               if (sum > {1'b0, slew_tgt[a]}) begin
                  slew_pos[a]  = slew_tgt[a];
                  slew_done[a] = 1'b1;
                  snaps_seen++;
               end else begin
                  slew_pos[a] = sum[15:0];
               end
            end else if (slew_pos[a] > slew_tgt[a]) begin
               if (slew_pos[a] - slew_tgt[a] < slew_step[a]) begin
                  slew_pos[a]  = slew_tgt[a];
                  slew_done[a] = 1'b1;
                  snaps_seen++;
               end else begin
                  slew_pos[a] = slew_pos[a] - slew_step[a];
               end
            end else begin
               slew_done[a] = 1'b1;
            end
         end
      end
      r = '{slew_pos[0], slew_pos[1], slew_pos[2], slew_done[0], slew_done[1],
            slew_done[2], slew_done[0] & slew_done[1] & slew_done[2]};
   endtask

   task automatic compare_positions(input pos_type want, input pos_type got);
      if (got.pos_base !== want.pos_base)
         flag($sformatf("pos_base: expected %0d, got %0d", want.pos_base, got.pos_base));
      if (got.pos_lower !== want.pos_lower)
         flag($sformatf("pos_lower: expected %0d, got %0d", want.pos_lower, got.pos_lower));
      if (got.pos_upper !== want.pos_upper)
         flag($sformatf("pos_upper: expected %0d, got %0d", want.pos_upper, got.pos_upper));
      if (got.done_base !== want.done_base)
         flag($sformatf("done_base: expected %0b, got %0b", want.done_base, got.done_base));
      if (got.done_lower !== want.done_lower)
         flag($sformatf("done_lower: expected %0b, got %0b", want.done_lower,
                        got.done_lower));
      if (got.done_upper !== want.done_upper)
         flag($sformatf("done_upper: expected %0b, got %0b", want.done_upper,
                        got.done_upper));
      if (got.move_done !== want.move_done)
         flag($sformatf("move_done: expected %0b, got %0b", want.move_done, got.move_done));
   endtask

   // scoreboard: results are checked before the item of the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            mon_got = '{rsp.pos_base, rsp.pos_lower, rsp.pos_upper, rsp.done_base,
                        rsp.done_lower, rsp.done_upper, rsp.move_done};
            if (pending_positions.size() == 0) begin
               flag("result with no item pending");
            end else begin
               mon_want = pending_positions.pop_front();
               compare_positions(mon_want, mon_got);
            end
         end
         if (req.valid && req.ready) begin
            mon_cmd = '{req.action, req.target_base, req.target_lower, req.target_upper,
                        req.step_base, req.step_lower, req.step_upper};
            if (mon_cmd.action == ACTION_LOAD)
               loads_seen++;
            else
               ticks_seen++;
            next_positions(mon_cmd, mon_want);
            if (row_typed)
               mon_want = row_want;
            pending_positions.push_back(mon_want);
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp.ready  <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic send_item(input cmd_type c, input logic typed, input pos_type want);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.action       <= c.action;
      req.target_base  <= c.target_base;
      req.target_lower <= c.target_lower;
      req.target_upper <= c.target_upper;
      req.step_base    <= c.step_base;
      req.step_lower   <= c.step_lower;
      req.step_upper   <= c.step_upper;
      row_typed        <= typed;
      row_want         <= want;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_positions.size() != 0) @(posedge clock);
   endtask

   function automatic field_type pick_target(input field_type near);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return FMAX;
         2: return near + field_type'($urandom_range(0, 40)) - 16'd20;
         3: return near;
         default: return field_type'($urandom);
      endcase
   endfunction

   function automatic field_type pick_step();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return FMAX;
         2, 3: return field_type'($urandom_range(1, 16));
         4, 5: return field_type'($urandom_range(1, 2000));
         default: return field_type'($urandom);
      endcase
   endfunction

   function automatic cmd_type noise_tick();
      return '{ACTION_TICK, field_type'($urandom), field_type'($urandom),
               field_type'($urandom), field_type'($urandom), field_type'($urandom),
               field_type'($urandom)};
   endfunction

   initial begin
      cmd_type c;
      int      ticks;
      logic    paused;
      reset            = 1'b1;
      calm             = 1'b0;
      paused           = 1'b0;
      errors           = 0;
      items_sent       = 0;
      loads_seen       = 0;
      ticks_seen       = 0;
      results_seen     = 0;
      snaps_seen       = 0;
      row_typed        = 1'b0;
      row_want         = '0;
      req.valid        = 1'b0;
      req.action       = ACTION_TICK;
      req.target_base  = '0;
      req.target_lower = '0;
      req.target_upper = '0;
      req.step_base    = '0;
      req.step_lower   = '0;
      req.step_upper   = '0;
      for (int a = 0; a < 3; a++) begin
         slew_pos[a]  = HOME;
         slew_tgt[a]  = HOME;
         slew_step[a] = '0;
         slew_done[a] = 1'b1;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      drain_results();

      // load with random content, then a run of ticks; some pure noise ticks
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= CALM_FROM)
            calm = 1'b1;
         if (!paused && items_sent >= PAUSE_AT) begin
            paused = 1'b1;
            drain_results();
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(noise_tick(), 1'b0, '0);
         end else begin
            c = '{ACTION_LOAD, pick_target(slew_pos[0]), pick_target(slew_pos[1]),
                  pick_target(slew_pos[2]), pick_step(), pick_step(), pick_step()};
            send_item(c, 1'b0, '0);
            ticks = $urandom_range(0, 24);
            for (int k = 0; k < ticks && items_sent < TOTAL_ITEMS; k++)
               send_item(noise_tick(), 1'b0, '0);
         end
      end
      drain_results();
      repeat (5) @(posedge clock);

      if (pending_positions.size() != 0)
         flag($sformatf("%0d expected results never arrived", pending_positions.size()));
      $display("%0d loads and %0d ticks sent, %0d results checked", loads_seen,
               ticks_seen, results_seen);
      $display("%0d axis snaps to target seen, %0d mismatches", snaps_seen, errors);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[three_axis_servo_slew_stepper_core.f]
sv/tass_pkg.sv
sv/tass_if.sv
sv/tass_axis.sv
sv/three_axis_servo_slew_stepper_core.sv
test/tb.sv
